[rtl/sgbs_pkg.sv]
package sgbs_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int PIDX_W  = 10;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 11;
  localparam int RES_W   = 11;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_AXIS0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_AXIS1 = 2'd1;
  localparam logic [CNT_W-1:0]     POINTS_RESET     = 11'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Depth of the request queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                      is_query;
    logic                      axis;
    logic [PIDX_W-1:0]         pidx;
    logic signed [VALUE_W-1:0] value;
    logic                      wr_ok;
  } sgbs_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] points_axis0;
    logic [CNT_W-1:0] points_axis1;
  } sgbs_cfg_t;

endpackage

[rtl/sgbs_ram.sv]
module sgbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/sgbs_front.sv]
module sgbs_front #(
  parameter int MAX_POINTS = sgbs_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_operation,
  input  logic                               in_axis,
  input  logic [sgbs_pkg::PIDX_W-1:0]        in_point_index,
  input  logic signed [sgbs_pkg::VALUE_W-1:0] in_value,
  output logic                               head_valid,
  output sgbs_pkg::sgbs_cmd_t                head,
  input  logic                               head_pop
);
  import sgbs_pkg::*;

  sgbs_cmd_t         q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  sgbs_cmd_t         cmd;
  logic              push_ok;
  logic              pop_ok;

  // Classify the request: queries pass through, writes past the table are dropped later.
  always_comb begin
    cmd.is_query = (in_operation == OP_QUERY);
    cmd.axis     = in_axis;
    cmd.pidx     = in_point_index;
    cmd.value    = in_value;
    cmd.wr_ok    = (32'(in_point_index) < 32'(MAX_POINTS));
  end

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign push_ok    = push && !full;
  assign pop_ok     = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("request queue count exceeds its depth");

  a_count_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(head_pop && head_valid)) |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted request not counted in queue");

  a_count_drops : assert property (@(posedge clk) disable iff (!rst_n)
    (head_pop && head_valid && !(push && !full)) |=> (count_r == $past(count_r) - 1'b1))
    else $error("drained request still counted in queue");

endmodule

[rtl/sgbs_back.sv]
module sgbs_back #(
  parameter int MAX_POINTS = sgbs_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sgbs_pkg::sgbs_cfg_t               cfg,
  input  logic                              head_valid,
  input  sgbs_pkg::sgbs_cmd_t               head,
  output logic                              head_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [sgbs_pkg::RES_W-1:0] out_bracket_index
);
  import sgbs_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int ADDR_W = IDX_W + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LAST   = 5'b00010,
    S_FIRST  = 5'b00100,
    S_BISECT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      ax_r, ax_nxt;
  logic signed [VALUE_W-1:0] x_r, x_nxt;
  logic [IDX_W-1:0]          nm1_r, nm1_nxt;
  logic signed [VALUE_W-1:0] glast_r, glast_nxt;
  logic                      asc_r, asc_nxt;
  logic [IDX_W-1:0]          lo_r, lo_nxt;
  logic [IDX_W-1:0]          hi_r, hi_nxt;
  logic [IDX_W-1:0]          mid_r, mid_nxt;
  logic [RES_W-1:0]          res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]          out_data_r, out_data_nxt;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;
  logic signed [VALUE_W-1:0] g;
  logic [CNT_W-1:0]          head_cnt;
  logic [IDX_W-1:0]          head_nm1;
  logic                      go_lo;
  logic [IDX_W-1:0]          b_lo, b_hi;
  logic [IDX_W:0]            mid_sum;

  sgbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (2 ** ADDR_W)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign g = $signed(ram_rdata);

  // Last index in use: a count of zero acts as one, a count past the table saturates.
  always_comb begin
    head_cnt = head.axis ? cfg.points_axis1 : cfg.points_axis0;
    if (head_cnt == '0) begin
      head_nm1 = '0;
    end else if (32'(head_cnt) > 32'(MAX_POINTS)) begin
      head_nm1 = IDX_W'(MAX_POINTS - 1);
    end else begin
      head_nm1 = IDX_W'(head_cnt - 1'b1);
    end
  end

  assign ram_we    = (state_r == S_IDLE) && head_valid && !head.is_query && head.wr_ok;
  assign ram_waddr = {head.axis, IDX_W'(head.pidx)};

  // One bisection step on the entry that was read in the previous cycle.
  always_comb begin
    go_lo   = ((x_r >= g) == asc_r);
    b_lo    = go_lo ? mid_r : lo_r;
    b_hi    = go_lo ? hi_r : mid_r;
    mid_sum = {1'b0, b_lo} + {1'b0, b_hi};
  end

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    x_nxt         = x_r;
    nm1_nxt       = nm1_r;
    glast_nxt     = glast_r;
    asc_nxt       = asc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    head_pop      = 1'b0;
    ram_raddr     = {ax_r, mid_r};
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          if (head.is_query) begin
            ax_nxt    = head.axis;
            x_nxt     = head.value;
            nm1_nxt   = head_nm1;
            ram_raddr = {head.axis, head_nm1};
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        glast_nxt = g;
        ram_raddr = {ax_r, {IDX_W{1'b0}}};
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        state_nxt = S_DONE;
        if (x_r > glast_r) begin
          res_nxt = RES_W'(nm1_r);
        end else if (x_r < g) begin
          res_nxt = '1;
        end else if (nm1_r <= IDX_W'(1)) begin
          res_nxt = '0;
        end else begin
          // Equal end points count as ascending.
          asc_nxt   = (glast_r >= g);
          lo_nxt    = '0;
          hi_nxt    = nm1_r;
          mid_nxt   = nm1_r >> 1;
          ram_raddr = {ax_r, nm1_r >> 1};
          state_nxt = S_BISECT;
        end
      end
      S_BISECT: begin
        lo_nxt  = b_lo;
        hi_nxt  = b_hi;
        mid_nxt = IDX_W'(mid_sum >> 1);
        if ({1'b0, b_hi} > {1'b0, b_lo} + 1'b1) begin
          ram_raddr = {ax_r, IDX_W'(mid_sum >> 1)};
        end else begin
          res_nxt   = RES_W'(b_lo);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ax_r       <= ax_nxt;
    x_r        <= x_nxt;
    nm1_r      <= nm1_nxt;
    glast_r    <= glast_nxt;
    asc_r      <= asc_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty             = !out_valid_r;
  assign out_bracket_index = $signed(out_data_r);

  a_bisect_span : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BISECT) |-> ({1'b0, hi_r} > {1'b0, lo_r} + 1'b1))
    else $error("bisection running on a collapsed bracket");

  a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished query");

  a_no_write_in_query : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST || state_r == S_FIRST || state_r == S_BISECT) |-> !ram_we)
    else $error("grid written while a query is in flight");

endmodule

[rtl/sorted_grid_bracket_search_core.sv]
// Bracket search over two sorted grids of signed Q16.16 points. A write request
// stores one point of one axis; a query request returns the lower bracket index
// of a coordinate: -1 below the first point, n-1 above the last, otherwise the
// bisection result, with the grid direction taken from its end points. Requests
// enter a four-deep queue; the back end drains a write in its idle state and a
// query through end-point reads and, where needed, a bisection, paced by the
// grid memory's single registered read port, one read per bisection step.
// Results wait in an output register while the next request is already being
// accepted. Grid points read before being written return undefined data. The
// user must write point counts through the cfg port only while the block is
// idle; the block itself does not enforce this.
module sorted_grid_bracket_search_core #(
  parameter int MAX_POINTS = sgbs_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_operation,
  input  logic                                in_axis,
  input  logic [sgbs_pkg::PIDX_W-1:0]         in_point_index,
  input  logic signed [sgbs_pkg::VALUE_W-1:0] in_value,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [sgbs_pkg::RES_W-1:0]   out_bracket_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgbs_pkg::CNT_W-1:0]          cfg_data
);
  import sgbs_pkg::*;

  sgbs_cfg_t cfg_r, cfg_nxt;
  logic      head_valid;
  sgbs_cmd_t head;
  logic      head_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_POINTS_AXIS0: cfg_nxt.points_axis0 = cfg_data;
        CFG_POINTS_AXIS1: cfg_nxt.points_axis1 = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.points_axis0 <= POINTS_RESET;
      cfg_r.points_axis1 <= POINTS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sgbs_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_operation   (in_operation),
    .in_axis        (in_axis),
    .in_point_index (in_point_index),
    .in_value       (in_value),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop)
  );

  sgbs_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_valid        (head_valid),
    .head              (head),
    .head_pop          (head_pop),
    .empty             (empty),
    .pop               (pop),
    .out_bracket_index (out_bracket_index)
  );

endmodule

[dv/sorted_grid_bracket_search_core_tb.sv]
module sorted_grid_bracket_search_core_tb;
  import sgbs_pkg::*;

  localparam int NPTS          = MAX_POINTS_DEF;
  localparam int AX1_PTS       = 128;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 300;
  localparam int PRINT_LIMIT   = 20;

  localparam logic [CFG_IDX_W-1:0]      CFG_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN  = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] Q_SEVEN    = 32'sh0007_0000;
  localparam logic signed [VALUE_W-1:0] Q_NEG3     = 32'shFFFD_0000;
  localparam logic signed [VALUE_W-1:0] Q_4P5      = 32'sh0004_8000;

  logic                      clk;
  logic                      rst_n;
  logic                      push;
  logic                      full;
  logic                      in_operation;
  logic                      in_axis;
  logic [PIDX_W-1:0]         in_point_index;
  logic signed [VALUE_W-1:0] in_value;
  logic                      empty;
  logic                      pop;
  logic signed [RES_W-1:0]   out_bracket_index;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CNT_W-1:0]          cfg_data;

  // Shadow copy of the two grids and the point counts.
  logic signed [VALUE_W-1:0] grid_model [2][NPTS];
  logic [CNT_W-1:0]          count_reg [2];
  logic signed [RES_W-1:0]   pending_brackets [$];

  int err_count        = 0;
  int items_sent       = 0;
  int queries_sent     = 0;
  int brackets_checked = 0;
  int cfg_writes       = 0;
  int idle_cycles      = 0;
  bit steady           = 1'b0;
  bit stall_pending    = 1'b0;
  int stall_len        = 0;

  sorted_grid_bracket_search_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_operation      (in_operation),
    .in_axis           (in_axis),
    .in_point_index    (in_point_index),
    .in_value          (in_value),
    .empty             (empty),
    .pop               (pop),
    .out_bracket_index (out_bracket_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int points_used(input logic [CNT_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > NPTS) return NPTS;
    return int'(r);
  endfunction

  function automatic logic signed [RES_W-1:0] locate_bracket(input logic ax,
                                                             input logic signed [VALUE_W-1:0] x);
    int n;
    int lo;
    int hi;
    int mid;
    bit asc;
    n = points_used(count_reg[ax]);
    if (x > grid_model[ax][n-1]) return RES_W'(n - 1);
    if (x < grid_model[ax][0]) return '1;
    asc = (grid_model[ax][n-1] >= grid_model[ax][0]);
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (hi + lo) / 2;
      if ((x >= grid_model[ax][mid]) == asc) lo = mid;
      else hi = mid;
    end
    return RES_W'(lo);
  endfunction

  // Coordinates cluster on and around the grid points so the bisection goes deep.
  function automatic logic signed [VALUE_W-1:0] pick_coord(input logic ax);
    int n;
    int i;
    longint a;
    longint b;
    n = points_used(count_reg[ax]);
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return grid_model[ax][i];
      4: return grid_model[ax][i] + 1;
      5: return grid_model[ax][i] - 1;
      6: return ($urandom_range(0, 1) != 0) ? VALUE_MAX : VALUE_MIN;
      7, 8: begin
        a = grid_model[ax][i];
        b = grid_model[ax][(i + 1 < n) ? i + 1 : i];
        return VALUE_W'((a + b) / 2);
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic send_item(input logic op, input logic ax, input logic [PIDX_W-1:0] pidx,
                           input logic signed [VALUE_W-1:0] val);
    if (!steady && $urandom_range(99) < 11) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push           <= 1'b1;
    in_operation   <= op;
    in_axis        <= ax;
    in_point_index <= pidx;
    in_value       <= val;
    do @(posedge clk); while (full);
    items_sent++;
    if (op == OP_QUERY) begin
      pending_brackets.insert(pending_brackets.size(), locate_bracket(ax, val));
      queries_sent++;
    end else begin
      grid_model[ax][pidx] = val;
    end
  endtask

  // Writes may still be draining after the last result, so wait out the pipeline.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    push <= 1'b0;
    while (pending_brackets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx == CFG_POINTS_AXIS0) count_reg[0] = data;
    else if (idx == CFG_POINTS_AXIS1) count_reg[1] = data;
    @(posedge clk);
  endtask

  task automatic load_sorted(input logic ax, input int n, input bit descending,
                             input int step_max);
    longint v;
    int step;
    v = longint'($signed($urandom())) / 2;
    for (int i = 0; i < n; i++) begin
      send_item(OP_WRITE, ax, PIDX_W'(i), VALUE_W'(v));
      step = $urandom_range(0, step_max);
      v = descending ? v - step : v + step;
    end
  endtask

  task automatic test_default_counts();
    send_item(OP_WRITE, 1'b0, PIDX_W'(0), Q_NEG3);
    send_item(OP_WRITE, 1'b0, PIDX_W'(1), Q_4P5);
    send_item(OP_WRITE, 1'b1, PIDX_W'(0), VALUE_MAX);
    send_item(OP_WRITE, 1'b1, PIDX_W'(1), VALUE_MIN);
    send_item(OP_QUERY, 1'b0, '1, VALUE_MIN);
    send_item(OP_QUERY, 1'b0, '0, Q_NEG3);
    send_item(OP_QUERY, 1'b0, '0, '0);
    send_item(OP_QUERY, 1'b0, '0, Q_4P5);
    send_item(OP_QUERY, 1'b0, '0, VALUE_MAX);
    send_item(OP_QUERY, 1'b1, '0, '0);
    send_item(OP_QUERY, 1'b1, '0, VALUE_MIN);
  endtask

  task automatic test_edge_cases();
    // A count of zero behaves as a single point.
    cfg_write(CFG_POINTS_AXIS0, '0);
    send_item(OP_QUERY, 1'b0, '0, Q_NEG3);
    send_item(OP_QUERY, 1'b0, '0, VALUE_MIN);
    send_item(OP_QUERY, 1'b0, '0, '0);
    // Equal end points count as an ascending grid.
    cfg_write(CFG_POINTS_AXIS1, CNT_W'(3));
    for (int i = 0; i < 3; i++) send_item(OP_WRITE, 1'b1, PIDX_W'(i), Q_SEVEN);
    send_item(OP_QUERY, 1'b1, '0, Q_SEVEN);
    send_item(OP_QUERY, 1'b1, '0, Q_SEVEN - 1);
    // A write to an unused register index must leave both counts alone.
    cfg_write(CFG_UNUSED, '1);
    send_item(OP_QUERY, 1'b1, '0, Q_SEVEN + 1);
    send_item(OP_WRITE, 1'b1, '1, 32'sh5A5A_A5A5);
    cfg_write(CFG_POINTS_AXIS1, CNT_W'(4));
    send_item(OP_WRITE, 1'b1, PIDX_W'(3), 32'sh0002_0000);
    send_item(OP_QUERY, 1'b1, '0, Q_SEVEN);
    send_item(OP_QUERY, 1'b1, '0, 32'sh0003_0000);
    send_item(OP_QUERY, 1'b1, '0, 32'sh0001_0000);
  endtask

  // Axis zero is filled completely and axis one up to AX1_PTS points, so every
  // later query reads written points.
  task automatic test_full_grids();
    bit ax;
    cfg_write(CFG_POINTS_AXIS0, CNT_W'(NPTS));
    cfg_write(CFG_POINTS_AXIS1, CNT_W'(AX1_PTS));
    load_sorted(1'b0, NPTS, 1'b0, 1 << 20);
    load_sorted(1'b1, AX1_PTS, 1'b1, 3);
    repeat (120) begin
      ax = $urandom_range(0, 1);
      send_item(OP_QUERY, ax, PIDX_W'($urandom()), pick_coord(ax));
    end
    cfg_write(CFG_POINTS_AXIS0, '1);
    cfg_write(CFG_POINTS_AXIS1, CNT_W'(AX1_PTS - 1));
    repeat (40) begin
      ax = $urandom_range(0, 1);
      send_item(OP_QUERY, ax, PIDX_W'($urandom()), pick_coord(ax));
    end
  endtask

  task automatic test_backpressure();
    bit ax;
    stall_len     = 400;
    stall_pending = 1'b1;
    repeat (60) begin
      ax = $urandom_range(0, 1);
      send_item(OP_QUERY, ax, PIDX_W'($urandom()), pick_coord(ax));
    end
  endtask

  task automatic test_random_grids();
    int goal;
    int phase;
    int r;
    bit ax;
    logic [CNT_W-1:0] cnt [2];
    goal  = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal) begin
      steady = (phase == 1);
      for (int a = 0; a < 2; a++) begin
        r = $urandom_range(0, 19);
        if (r == 0) cnt[a] = '0;
        else if (r == 1) begin
          if (a == 0) cnt[a] = ($urandom_range(0, 1) != 0) ? CNT_W'(NPTS) : '1;
          else cnt[a] = CNT_W'(AX1_PTS);
        end
        else if (r < 15) cnt[a] = CNT_W'($urandom_range(1, 12));
        else cnt[a] = CNT_W'($urandom_range(13, 80));
      end
      cfg_write(CFG_POINTS_AXIS0, cnt[0]);
      cfg_write(CFG_POINTS_AXIS1, cnt[1]);
      for (int a = 0; a < 2; a++) begin
        if (points_used(cnt[a]) < NPTS && $urandom_range(0, 4) != 0)
          load_sorted(a[0], points_used(cnt[a]), $urandom_range(0, 1),
                      1 << $urandom_range(0, 20));
      end
      repeat ($urandom_range(15, 40)) begin
        ax = $urandom_range(0, 1);
        r  = $urandom_range(0, 99);
        if (r < 75)
          send_item(OP_QUERY, ax, PIDX_W'($urandom()), pick_coord(ax));
        else if (r < 85)
          send_item(OP_WRITE, ax, PIDX_W'($urandom_range(0, points_used(count_reg[ax]) - 1)),
                    $urandom());
        else
          send_item(OP_WRITE, ax, PIDX_W'($urandom()), $urandom());
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin : result_taker
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (stall_pending) begin
        stall_pending = 1'b0;
        pop <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end else begin
        pop <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic signed [RES_W-1:0] want;
    if (rst_n && pop && !empty) begin
      if (pending_brackets.size() == 0) begin
        report_mismatch($sformatf("result %0d with no query waiting", out_bracket_index));
      end else begin
        want = pending_brackets.pop_front();
        brackets_checked++;
        if (out_bracket_index !== want)
          report_mismatch($sformatf("bracket_index %0d, expected %0d",
                                    out_bracket_index, want));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no request moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    push           = 1'b0;
    in_operation   = OP_WRITE;
    in_axis        = 1'b0;
    in_point_index = '0;
    in_value       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_POINTS_AXIS0;
    cfg_data       = '0;
    count_reg[0]   = POINTS_RESET;
    count_reg[1]   = POINTS_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_counts();
    test_edge_cases();
    test_full_grids();
    test_backpressure();
    test_random_grids();

    push <= 1'b0;
    while (pending_brackets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d queries), checked %0d bracket results, %0d count writes.",
             items_sent, queries_sent, brackets_checked, cfg_writes);
    $display("Grids from one point to the full table, both directions, with stalls.");
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
